// ===== src/assert_macros.svh =====
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every clock edge outside reset.
`define CHK_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("check failed");

// Next-cycle implication checked outside reset.
`define CHK_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("check failed");

`endif

// ===== src/vpuv_pkg.sv =====
package vpuv_pkg;

  localparam int CoordW  = 32;
  localparam int AccW    = 64;
  localparam int QuotW   = 41;
  localparam int NumRegs = 8;
  localparam int CfgIdxW = 4;

  // Near plane threshold in Q34.30.
  localparam logic signed [AccW-1:0] NearQ30 = 64'sd1073742;
  localparam logic [QuotW-1:0]        QuotCap = 41'h100_0000_0000;
  localparam logic signed [CoordW-1:0] OneQ16 = 32'sd65536;

  typedef logic signed [CoordW-1:0] coord_t;
  typedef logic signed [AccW-1:0]   acc_t;

  // Control that travels beside each lane of the divider.
  typedef struct packed {
    logic valid;
    logic neg;
    logic big;
  } div_ctl_t;

  // Saturate a wide signed value to 32 bits.
  function automatic coord_t sat32(input logic signed [QuotW+1:0] v);
    logic signed [QuotW+1:0] hi;
    logic signed [QuotW+1:0] lo;
    hi = (QuotW+2)'(32'sh7fff_ffff);
    lo = ~hi;
    if (v > hi) begin
      sat32 = 32'sh7fff_ffff;
    end else if (v < lo) begin
      sat32 = 32'sh8000_0000;
    end else begin
      sat32 = v[CoordW-1:0];
    end
  endfunction

endpackage

// ===== src/vertex_projection_to_uv_unit.sv =====
// Pipeline from input transfer to result: 3 front stages for products,
// row sums and magnitudes, 20 divider stages and 1 output stage, with the
// divider pipeline giving two quotient bits per stage.
// Throughput: one vertex per cycle; the pipeline advances whenever the
// output register is empty or being taken, so a stall loses nothing.
// Reset (synchronous, rst_n low) clears the matrix to zero and all valid bits.
module vertex_projection_to_uv_unit import vpuv_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [63:0]        cfg_data,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [95:0]        in_tdata,   // vertex_x, vertex_y, vertex_z
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [95:0]        out_tdata,  // tex_u, tex_v, depth
  output logic               out_tuser   // clipped
);

  logic [63:0] mvp_r [NumRegs];
  logic        en;

  // Configuration writes; unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NumRegs; i++) mvp_r[i] <= '0;
    end else if (cfg_we && cfg_index < CfgIdxW'(NumRegs)) begin
      mvp_r[cfg_index[2:0]] <= cfg_data;
    end
  end

  function automatic coord_t ent(input int row, input int col);
    logic [63:0] r;
    r = mvp_r[3'(row*2 + col/2)];
    ent = (col % 2 == 1) ? r[31:0] : r[63:32];
  endfunction

  // Stage 1: twelve products (Q32.32).
  coord_t vx, vy, vz;
  assign vx = in_tdata[31:0];
  assign vy = in_tdata[63:32];
  assign vz = in_tdata[95:64];

  logic s1_valid_r, s2_valid_r, s3_valid_r, s4_valid_r;
  acc_t prod_r [4][3];
  coord_t trn_r [4];

  always_ff @(posedge clk) begin
    if (!rst_n) s1_valid_r <= 1'b0;
    else if (en) s1_valid_r <= in_tvalid;
    if (en) begin
      for (int r = 0; r < 4; r++) begin
        prod_r[r][0] <= acc_t'(ent(r, 0)) * acc_t'(vx);
        prod_r[r][1] <= acc_t'(ent(r, 1)) * acc_t'(vy);
        prod_r[r][2] <= acc_t'(ent(r, 2)) * acc_t'(vz);
        trn_r[r]     <= ent(r, 3);
      end
    end
  end

  // Stage 2: scale to Q34.30 and sum each row.
  acc_t clip_r [4];
  always_ff @(posedge clk) begin
    if (!rst_n) s2_valid_r <= 1'b0;
    else if (en) s2_valid_r <= s1_valid_r;
    if (en) begin
      for (int r = 0; r < 4; r++) begin
        clip_r[r] <= (prod_r[r][0] >>> 2) + (prod_r[r][1] >>> 2)
                   + (prod_r[r][2] >>> 2) + (acc_t'(trn_r[r]) <<< 14);
      end
    end
  end

  // Stage 3: near test, signs and magnitudes.
  logic [AccW-1:0] mag_r [3];
  logic [AccW-1:0] wmag_r;
  logic            neg_r [3];
  logic            near_r;
  always_ff @(posedge clk) begin
    if (!rst_n) s3_valid_r <= 1'b0;
    else if (en) s3_valid_r <= s2_valid_r;
    if (en) begin
      near_r <= (clip_r[3] > -NearQ30) && (clip_r[3] < NearQ30);
      wmag_r <= clip_r[3][AccW-1] ? -clip_r[3] : clip_r[3];
      for (int c = 0; c < 3; c++) begin
        mag_r[c] <= clip_r[c][AccW-1] ? -clip_r[c] : clip_r[c];
        neg_r[c] <= clip_r[c][AccW-1] != clip_r[3][AccW-1];
      end
    end
  end

  // Stage 4: keep the divisor nonzero on the near path.
  logic [AccW-1:0] den;
  assign den = near_r ? 64'd1 : wmag_r;

  // Near flag delay line alongside the divider.
  localparam int DivLat = 20;
  logic near_d_r [DivLat];
  always_ff @(posedge clk) begin
    if (en) begin
      near_d_r[0] <= near_r;
      for (int i = 1; i < DivLat; i++) near_d_r[i] <= near_d_r[i-1];
    end
  end
  assign s4_valid_r = s3_valid_r;

  logic [QuotW-1:0] q [3];
  logic             qn [3];
  logic             qv [3];
  for (genvar c = 0; c < 3; c++) begin : g_div
    vpuv_divider u_div (
      .clk(clk), .rst_n(rst_n), .en(en), .in_valid(s4_valid_r),
      .in_num(mag_r[c]), .in_den(den), .in_neg(neg_r[c]),
      .out_quot(q[c]), .out_neg(qn[c]), .out_valid(qv[c])
    );
  end

  // Signed quotients and output formatting.
  logic signed [QuotW+1:0] sq [3];
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      sq[c] = qn[c] ? -$signed({2'b0, q[c]}) : $signed({2'b0, q[c]});
    end
  end

  logic        out_valid_r;
  logic [95:0] out_data_r;
  logic        out_clip_r;
  assign en = !out_valid_r || out_tready;
  assign in_tready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (en) out_valid_r <= qv[0] && qv[1] && qv[2];
    if (en) begin
      out_clip_r <= near_d_r[DivLat-1];
      if (near_d_r[DivLat-1]) begin
        out_data_r <= {OneQ16, 32'd0, 32'd0};
      end else begin
        out_data_r <= {sat32(sq[2]),
                       sat32((sq[1] + (QuotW+2)'(65536)) >>> 1),
                       sat32((sq[0] + (QuotW+2)'(65536)) >>> 1)};
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_clip_r;

endmodule

// ===== src/vpuv_divider.sv =====
// Pipelined restoring divider: magnitude of c / w in Q16.16, truncated,
// capped at 2^40. Two quotient bits per stage over DivStages registered
// stages; one division may enter every cycle while en is high.
module vpuv_divider import vpuv_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             in_valid,
  input  logic [AccW-1:0]  in_num,
  input  logic [AccW-1:0]  in_den,
  input  logic             in_neg,
  output logic [QuotW-1:0] out_quot,
  output logic             out_neg,
  output logic             out_valid
);

  // Integer part needs at most 24 bits (beyond that the cap applies);
  // with 16 fraction bits that is 40 quotient bits, two per stage.
  localparam int QBits     = 40;
  localparam int StepsPerS = 2;
  localparam int DivStages = QBits / StepsPerS;
  localparam int NumW      = AccW + 16;

  // Remainder, shifted dividend, quotient, divisor per stage.
  logic [AccW:0]        rem_r  [DivStages+1];
  logic [NumW-1:0]      num_r  [DivStages+1];
  logic [QBits-1:0]     quo_r  [DivStages+1];
  logic [AccW-1:0]      den_r  [DivStages+1];
  div_ctl_t             ctl_r  [DivStages+1];

  // The quotient overflows 2^40 exactly when num >= den * 2^24 (integer).
  // Otherwise the top bits of the scaled dividend, num >> 24, are below den
  // and serve as the starting remainder, so only the last QBits steps remain.
  always_comb begin
    rem_r[0] = {{(AccW+1-QBits){1'b0}}, in_num[AccW-1:AccW-QBits]};
    num_r[0] = {in_num[AccW-QBits-1:0], 16'd0, {QBits{1'b0}}};
    quo_r[0] = '0;
    den_r[0] = in_den;
    ctl_r[0].valid = in_valid;
    ctl_r[0].neg   = in_neg;
    ctl_r[0].big   = (in_num >> 24) >= in_den;
  end

  for (genvar s = 0; s < DivStages; s++) begin : g_stage
    logic [AccW:0]    rem_nxt;
    logic [NumW-1:0]  num_nxt;
    logic [QBits-1:0] quo_nxt;
    always_comb begin
      rem_nxt = rem_r[s];
      num_nxt = num_r[s];
      quo_nxt = quo_r[s];
      for (int k = 0; k < StepsPerS; k++) begin
        rem_nxt = {rem_nxt[AccW-1:0], num_nxt[NumW-1]};
        num_nxt = {num_nxt[NumW-2:0], 1'b0};
        if (rem_nxt >= {1'b0, den_r[s]}) begin
          rem_nxt = rem_nxt - {1'b0, den_r[s]};
          quo_nxt = {quo_nxt[QBits-2:0], 1'b1};
        end else begin
          quo_nxt = {quo_nxt[QBits-2:0], 1'b0};
        end
      end
    end
    // Skip the leading bits: first stage starts at bit position QBits-1,
    // so pre-shift the dividend by NumW-QBits at entry instead.
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        ctl_r[s+1].valid <= 1'b0;
      end else if (en) begin
        ctl_r[s+1].valid <= ctl_r[s].valid;
      end
      if (en) begin
        rem_r[s+1]      <= rem_nxt;
        num_r[s+1]      <= num_nxt;
        quo_r[s+1]      <= quo_nxt;
        den_r[s+1]      <= den_r[s];
        ctl_r[s+1].neg  <= ctl_r[s].neg;
        ctl_r[s+1].big  <= ctl_r[s].big;
      end
    end
  end

  assign out_quot  = ctl_r[DivStages].big ? QuotCap : {1'b0, quo_r[DivStages]};
  assign out_neg   = ctl_r[DivStages].neg;
  assign out_valid = ctl_r[DivStages].valid;

endmodule

// ===== src/vpuv_checker.sv =====
`include "assert_macros.svh"
module vpuv_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [95:0] out_tdata,
  input logic        out_tuser
);
  `CHK_NEXT(a_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))
  `CHK_IMPL(a_clip_val, out_tvalid && out_tuser, out_tdata == {32'd65536, 64'd0})
  `CHK_IMPL(a_ready, out_tvalid && !out_tready, !in_tready)
  `CHK_NEXT(a_rst, !rst_n, !out_tvalid)
endmodule

bind vertex_projection_to_uv_unit vpuv_checker u_chk (.*);

// ===== sim/testbench.sv =====
module testbench import vpuv_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } vertex_t;

  typedef struct {
    logic [31:0] u;
    logic [31:0] v;
    logic [31:0] d;
    logic        clipped;
  } uv_t;

  localparam int DrainCycles = 60;

  logic         clk;
  logic         rst_n;
  logic         cfg_we;
  logic [3:0]   cfg_index;
  logic [63:0]  cfg_data;
  logic         in_tvalid;
  logic         in_tready;
  logic [95:0]  in_tdata;   // vertex_x, vertex_y, vertex_z
  logic         out_tvalid;
  logic         out_tready;
  logic [95:0]  out_tdata;  // tex_u, tex_v, depth
  logic         out_tuser;  // clipped

  vertex_projection_to_uv_unit dut (.*);

  // Local copy of the matrix registers.
  logic [63:0] mvp[8];

  vertex_t vertex_q[$];
  uv_t     uv_expected[$];
  int      send_idle_pct;
  int      recv_idle_pct;
  int      mismatches;
  int      vertices_sent;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #100ms;
    $display("CHECK FAILED");
    $finish;
  end

  function automatic logic signed [63:0] mat_entry(int row, int col);
    logic [63:0] r;
    r = mvp[row * 2 + col / 2];
    return (col % 2) ? $signed(r[31:0]) : $signed(r[63:32]);
  endfunction

  // One row of the matrix product in Q34.30; products are floored by two bits.
  function automatic logic signed [63:0] clip_coord(int row, vertex_t vx);
    logic signed [63:0] acc;
    acc = (mat_entry(row, 0) * 64'(vx.x)) >>> 2;
    acc += (mat_entry(row, 1) * 64'(vx.y)) >>> 2;
    acc += (mat_entry(row, 2) * 64'(vx.z)) >>> 2;
    acc += mat_entry(row, 3) * 64'sd16384;
    return acc;
  endfunction

  // Quotient in Q16.16 with truncated magnitude, held at 2^40.
  function automatic logic signed [63:0] quotient_q16(logic signed [63:0] c,
                                                       logic signed [63:0] w);
    logic        neg;
    logic [63:0] cm;
    logic [63:0] wm;
    logic [127:0] q;
    neg = (c < 0) != (w < 0);
    cm = (c < 0) ? -c : c;
    wm = (w < 0) ? -w : w;
    q = {cm, 16'h0} / {64'h0, wm};
    if (q > 128'(QuotCap)) q = 128'(QuotCap);
    return neg ? -$signed(q[63:0]) : $signed(q[63:0]);
  endfunction

  function automatic logic [31:0] clamp32(logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'h7fff_ffff;
    if (v < -64'sd2147483648) return 32'h8000_0000;
    return v[31:0];
  endfunction

  function automatic uv_t project_vertex(vertex_t vx);
    uv_t r;
    logic signed [63:0] cx, cy, cz, cw;
    cx = clip_coord(0, vx);
    cy = clip_coord(1, vx);
    cz = clip_coord(2, vx);
    cw = clip_coord(3, vx);
    if (cw > -NearQ30 && cw < NearQ30) begin
      r.u = '0;
      r.v = '0;
      r.d = 32'd65536;
      r.clipped = 1'b1;
    end else begin
      r.u = clamp32((quotient_q16(cx, cw) + 64'sd65536) >>> 1);
      r.v = clamp32((quotient_q16(cy, cw) + 64'sd65536) >>> 1);
      r.d = clamp32(quotient_q16(cz, cw));
      r.clipped = 1'b0;
    end
    return r;
  endfunction

  // Driver: presents queued vertices and records the expected coordinates.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        vertex_t vx;
        vx = vertex_q.pop_front();
        uv_expected = {uv_expected, project_vertex(vx)};
        vertices_sent++;
      end
      if ((!in_tvalid || in_tready) ) begin
        if (vertex_q.size() != 0 &&
            $urandom_range(99) >= send_idle_pct) begin
          in_tvalid <= 1'b1;
          in_tdata  <= {vertex_q[0].z, vertex_q[0].y, vertex_q[0].x};
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each result transfer against the oldest expectation.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        uv_t e;
        if (uv_expected.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("Unexpected result transfer %h", out_tdata);
        end else begin
          e = uv_expected.pop_front();
          if (out_tdata[31:0] !== e.u || out_tdata[63:32] !== e.v ||
              out_tdata[95:64] !== e.d || out_tuser !== e.clipped) begin
            mismatches++;
            if (mismatches <= 10)
              $display("Mismatch: expected u=%h v=%h d=%h c=%b, got u=%h v=%h d=%h c=%b",
                       e.u, e.v, e.d, e.clipped, out_tdata[31:0], out_tdata[63:32],
                       out_tdata[95:64], out_tuser);
          end
        end
      end
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic write_reg(int idx, logic [63:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= 4'(idx);
    cfg_data  <= val;
    if (idx < 8) mvp[idx] = val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Waits until every queued vertex has been sent and every result checked.
  task automatic drain();
    while (vertex_q.size() != 0 || in_tvalid || uv_expected.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(4))
      0: return $urandom();
      1: return 32'($signed($urandom_range(20 * 65536)) - 10 * 65536);
      2: return {$urandom_range(1) ? 16'hffff : 16'h0000, 16'($urandom())};
      default: return 32'($signed($urandom_range(4 * 65536)) - 2 * 65536);
    endcase
  endfunction

  function automatic logic [31:0] rand_entry();
    case ($urandom_range(5))
      0: return $urandom();
      1: return 32'($signed($urandom_range(4 * 65536)) - 2 * 65536);
      2: return 32'($signed($urandom_range(2000)) - 1000);
      default: return 32'($signed($urandom_range(2 * 65536)) - 65536);
    endcase
  endfunction

  task automatic push_vertex(logic [31:0] x, logic [31:0] y, logic [31:0] z);
    vertex_t vx;
    vx.x = x;
    vx.y = y;
    vx.z = z;
    vertex_q = {vertex_q, vx};
  endtask

  task automatic random_matrix();
    for (int i = 0; i < 8; i++) write_reg(i, {rand_entry(), rand_entry()});
    // Often keep w near 1 in the last column so most vertices are not clipped.
    if ($urandom_range(3) != 0) write_reg(7, {rand_entry() >>> 4, 32'd65536});
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    out_tready = 1'b0;
    mismatches = 0;
    vertices_sent = 0;
    send_idle_pct = 36;
    recv_idle_pct = 57;
    for (int i = 0; i < 8; i++) mvp[i] = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Zero matrix after reset: everything is clipped.
    push_vertex(32'h7fff_ffff, 32'h8000_0000, 32'h0);
    drain();

    // Identity with unit w: plain pass-through plus a division by one.
    write_reg(0, {32'd65536, 32'd0});
    write_reg(1, {32'd0, 32'd0});
    write_reg(2, {32'd0, 32'd65536});
    write_reg(3, {32'd0, 32'd0});
    write_reg(4, {32'd0, 32'd0});
    write_reg(5, {32'd65536, 32'd0});
    write_reg(6, {32'd0, 32'd0});
    write_reg(7, {32'd0, 32'd65536});
    write_reg(9, 64'hffff_ffff_ffff_ffff);  // unknown index, ignored
    push_vertex(32'h0, 32'h0, 32'h0);
    push_vertex(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    push_vertex(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    push_vertex(32'h0001_0000, 32'hffff_0000, 32'h0000_8000);
    push_vertex(32'hffff_ffff, 32'h0000_0001, 32'h5555_5555);
    push_vertex(32'haaaa_aaaa, 32'h5555_5555, 32'haaaa_aaaa);
    drain();

    // w taken from z: near clip boundary, tiny w giving a huge quotient.
    write_reg(7, {32'd65536, 32'd0});
    push_vertex(32'h0001_0000, 32'h0001_0000, 32'd65);     // |w| below threshold
    push_vertex(32'h0001_0000, 32'h0001_0000, 32'd66);     // just above threshold
    push_vertex(32'h0001_0000, 32'h0001_0000, -32'sd66);
    push_vertex(32'h7fff_ffff, 32'h8000_0000, 32'd70);    // huge quotient
    push_vertex(32'h7fff_ffff, 32'h8000_0000, -32'sd70);
    push_vertex(32'h0003_0000, 32'hfffd_0000, 32'hfffe_0000);
    // Extreme matrix entries.
    drain();
    for (int i = 0; i < 7; i++) write_reg(i, {32'h8000_0000, 32'h7fff_ffff});
    write_reg(7, {32'h7fff_ffff, 32'h8000_0000});
    push_vertex(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    push_vertex(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    push_vertex(32'h8000_0000, 32'h7fff_ffff, 32'h0);
    push_vertex(32'h0, 32'h0, 32'h0);
    drain();

    // Random phases, each with a fresh matrix; idling pattern changes by thirds.
    for (int phase = 0; phase < 12; phase++) begin
      if (phase == 4) begin
        send_idle_pct = 57;
        recv_idle_pct = 36;
      end else if (phase == 8) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      random_matrix();
      for (int n = 0; n < 104; n++) push_vertex(rand_coord(), rand_coord(), rand_coord());
      drain();
    end

    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
